FILE: hw/rtl/mos6502_core_subset_assert.svh
// Assertion macros used by the checker of the 6502 subset core.
// Each macro expands to one labeled concurrent assertion on the rising edge of aclk,
// disabled while aresetn is low.
`ifndef MOS6502_CORE_SUBSET_ASSERT_SVH
`define MOS6502_CORE_SUBSET_ASSERT_SVH

// The consequent is checked at the same edge as the antecedent.
`define MCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked at the edge after the antecedent.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, constants and the opcode decoder of the 6502 subset core.
// ----------------------------------------------------------------------------
package mcs_pkg;

    typedef enum logic [1:0] {
        OP_RESPONSE = 2'd0,
        OP_RESTART  = 2'd1,
        OP_RESUME   = 2'd2,
        OP_NONE     = 2'd3
    } operation_t;

    typedef enum logic [2:0] {
        PH_OPC, PH_LO, PH_HI, PH_PLO, PH_PHI, PH_DATA, PH_WRITE
    } phase_t;

    typedef enum logic [3:0] {
        M_IMP, M_IMM, M_ZPG, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_XIND, M_INDY, M_IND
    } mode_t;

    typedef enum logic [4:0] {
        K_ILL, K_BRK, K_ADC, K_SBC, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY,
        K_TAX, K_TAY, K_TSX, K_TXA, K_TXS, K_TYA, K_JMP, K_CLC, K_SEC
    } kind_t;

    typedef struct packed {
        mode_t mode;
        kind_t kind;
    } decode_t;

    localparam logic [15:0] RESET_PC     = 16'hC000;
    localparam logic [7:0]  RESET_SP     = 8'hFF;
    localparam logic [7:0]  RESET_STATUS = 8'h20;

    // Status bit positions.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Result word layout on the output channel.
    localparam int OUT_WIDTH     = 88;
    localparam int OUT_REQ_BIT   = 0;
    localparam int OUT_ADDR_LSB  = 1;
    localparam int OUT_WDATA_LSB = 17;
    localparam int OUT_FLAGS_LSB = 57;
    localparam int OUT_HALT_BIT  = 81;
    localparam int OUT_ILL_BIT   = 82;

    function automatic mode_t group_one_mode(logic [2:0] col);
        mode_t m;
        unique case (col)
            3'd0: m = M_XIND;
            3'd1: m = M_ZPG;
            3'd2: m = M_IMM;
            3'd3: m = M_ABS;
            3'd4: m = M_INDY;
            3'd5: m = M_ZPX;
            3'd6: m = M_ABY;
            default: m = M_ABX;
        endcase
        return m;
    endfunction

    function automatic decode_t decode(logic [7:0] op);
        decode_t    r;
        logic [2:0] hi;
        logic [2:0] col;
        hi     = op[7:5];
        col    = op[4:2];
        r.mode = M_IMP;
        r.kind = K_ILL;
        unique case (op)
            8'h00: r.kind = K_BRK;
            8'h18: r.kind = K_CLC;
            8'h38: r.kind = K_SEC;
            8'hAA: r.kind = K_TAX;
            8'hA8: r.kind = K_TAY;
            8'hBA: r.kind = K_TSX;
            8'h8A: r.kind = K_TXA;
            8'h9A: r.kind = K_TXS;
            8'h98: r.kind = K_TYA;
            8'h4C: begin r.kind = K_JMP; r.mode = M_ABS; end
            8'h6C: begin r.kind = K_JMP; r.mode = M_IND; end
            8'hA2: begin r.kind = K_LDX; r.mode = M_IMM; end
            8'hA6: begin r.kind = K_LDX; r.mode = M_ZPG; end
            8'hAE: begin r.kind = K_LDX; r.mode = M_ABS; end
            8'hB6: begin r.kind = K_LDX; r.mode = M_ZPY; end
            8'hBE: begin r.kind = K_LDX; r.mode = M_ABY; end
            8'hA0: begin r.kind = K_LDY; r.mode = M_IMM; end
            8'hA4: begin r.kind = K_LDY; r.mode = M_ZPG; end
            8'hAC: begin r.kind = K_LDY; r.mode = M_ABS; end
            8'hB4: begin r.kind = K_LDY; r.mode = M_ZPX; end
            8'hBC: begin r.kind = K_LDY; r.mode = M_ABX; end
            8'h86: begin r.kind = K_STX; r.mode = M_ZPG; end
            8'h8E: begin r.kind = K_STX; r.mode = M_ABS; end
            8'h96: begin r.kind = K_STX; r.mode = M_ZPY; end
            8'h84: begin r.kind = K_STY; r.mode = M_ZPG; end
            8'h8C: begin r.kind = K_STY; r.mode = M_ABS; end
            8'h94: begin r.kind = K_STY; r.mode = M_ZPX; end
            8'hEB: begin r.kind = K_SBC; r.mode = M_IMM; end
            default: begin
                // Group-one column layout for ADC, SBC, LDA and STA.
                if (op[1:0] == 2'b01) begin
                    if (hi == 3'd3) begin
                        r.kind = K_ADC;
                        r.mode = group_one_mode(col);
                    end else if (hi == 3'd7) begin
                        r.kind = K_SBC;
                        r.mode = group_one_mode(col);
                    end else if (hi == 3'd5) begin
                        r.kind = K_LDA;
                        r.mode = group_one_mode(col);
                    end else if (hi == 3'd4 && col != 3'd2) begin
                        r.kind = K_STA;
                        r.mode = group_one_mode(col);
                    end
                end
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/mos6502_core_subset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos6502_core_subset
// Binary 6502 subset core that advances one bus access per accepted request.
// ----------------------------------------------------------------------------
// The core is driven by its bus: every request on the slave channel carries an
// operation in s_tuser (bus response, restart or resume) and, for a bus response,
// the byte that was read for the access the core asked for last. Every accepted
// request yields exactly one result on the master channel: the next access the
// core wants (address, read or write, store data), the register file, the
// program counter and the halt and illegal-opcode status.
// A request accepted at one edge shows its result from the next edge on. Unless
// the receiver stalls, a new request can be accepted in every cycle, so one bus
// access per cycle is sustained; the opcode decode and the 16-bit address adders
// between the state registers and the result register set the clock period.
// After reset the core sits at 0xC000 (or at start_address after a restart) and
// regards the opcode read there as already requested, so the first request
// should carry that opcode byte. The user must load the start address through
// cfg_wr_en and cfg_wr_data only while the core is idle; the core does not enforce it.
// When the receiver stalls, the result stays in the output register and the
// core accepts one more request only when that result is being taken in the
// same cycle; s_tready is low otherwise.
// ----------------------------------------------------------------------------
module mos6502_core_subset (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] read_data
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] request_valid, [16:1] bus_address, [24:17] write_data,
    // [32:25] accumulator, [40:33] index_x, [48:41] index_y,
    // [56:49] stack_pointer, [64:57] flags, [80:65] program_counter,
    // [81] halted, [82] illegal, [87:83] zero
    output logic [87:0] m_tdata,
    output logic [0:0]  m_tuser    // [0] is_write
);

    // Architectural state.
    logic [15:0]     start_addr_reg;
    logic [7:0]      acc_reg, acc_next;
    logic [7:0]      x_reg, x_next;
    logic [7:0]      y_reg, y_next;
    logic [7:0]      sp_reg, sp_next;
    logic [7:0]      status_reg, status_next;
    logic [15:0]     pc_reg, pc_next;
    mcs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      opcode_reg, opcode_next;
    logic [15:0]     ea_reg, ea_next;
    logic [15:0]     ptr_reg, ptr_next;
    logic            halt_reg, halt_next;
    logic            illegal_reg, illegal_next;

    // Output register.
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic                s_fire;
    mcs_pkg::operation_t op_in;
    logic [7:0]          rd;
    mcs_pkg::decode_t    dec_op;    // opcode being executed
    mcs_pkg::decode_t    dec_rd;    // byte arriving as a new opcode
    mcs_pkg::decode_t    dec_nx;    // opcode after this step
    mcs_pkg::phase_t     store_phase;

    // Value unit for ADC, SBC and loads.
    logic [7:0] alu_m;
    logic [8:0] alu_sum;
    logic [7:0] val_acc, val_x, val_y, val_status;

    // Implied instructions.
    logic [7:0] imp_acc, imp_x, imp_y, imp_sp, imp_status;
    logic       imp_halt, imp_illegal, imp_brk;

    // Address adders.
    logic [15:0] abs_base, abs_index, ind_base, ind_index;

    // Request fields of the result.
    logic        req_valid;
    logic [15:0] req_addr;
    logic        req_write;
    logic [7:0]  req_wdata;

    function automatic logic [7:0] with_nz(logic [7:0] st, logic [7:0] v);
        logic [7:0] r;
        r                 = st;
        r[mcs_pkg::FLAG_Z] = (v == 8'h00);
        r[mcs_pkg::FLAG_N] = v[7];
        return r;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign op_in    = mcs_pkg::operation_t'(s_tuser);
    assign rd       = s_tdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign dec_op = mcs_pkg::decode(opcode_reg);
    assign dec_rd = mcs_pkg::decode(rd);
    assign dec_nx = mcs_pkg::decode(opcode_next);

    assign store_phase = (dec_op.kind == mcs_pkg::K_STA || dec_op.kind == mcs_pkg::K_STX ||
                          dec_op.kind == mcs_pkg::K_STY) ? mcs_pkg::PH_WRITE
                                                         : mcs_pkg::PH_DATA;

    // SBC adds the complement of the operand with carry in.
    assign alu_m   = (dec_op.kind == mcs_pkg::K_SBC) ? ~rd : rd;
    assign alu_sum = {1'b0, acc_reg} + {1'b0, alu_m} + {8'h00, status_reg[mcs_pkg::FLAG_C]};

    always_comb begin
        val_acc    = acc_reg;
        val_x      = x_reg;
        val_y      = y_reg;
        val_status = status_reg;
        unique case (dec_op.kind)
            mcs_pkg::K_ADC, mcs_pkg::K_SBC: begin
                val_acc                     = alu_sum[7:0];
                val_status                  = with_nz(status_reg, alu_sum[7:0]);
                val_status[mcs_pkg::FLAG_C] = alu_sum[8];
                val_status[mcs_pkg::FLAG_V] = ~(acc_reg[7] ^ alu_m[7]) &
                                              (acc_reg[7] ^ alu_sum[7]);
            end
            mcs_pkg::K_LDA: begin
                val_acc    = rd;
                val_status = with_nz(status_reg, rd);
            end
            mcs_pkg::K_LDX: begin
                val_x      = rd;
                val_status = with_nz(status_reg, rd);
            end
            mcs_pkg::K_LDY: begin
                val_y      = rd;
                val_status = with_nz(status_reg, rd);
            end
            default: ;
        endcase
    end

    always_comb begin
        imp_acc     = acc_reg;
        imp_x       = x_reg;
        imp_y       = y_reg;
        imp_sp      = sp_reg;
        imp_status  = status_reg;
        imp_halt    = 1'b0;
        imp_illegal = 1'b0;
        imp_brk     = 1'b0;
        unique case (dec_rd.kind)
            mcs_pkg::K_TAX: begin imp_x = acc_reg; imp_status = with_nz(status_reg, acc_reg); end
            mcs_pkg::K_TAY: begin imp_y = acc_reg; imp_status = with_nz(status_reg, acc_reg); end
            mcs_pkg::K_TSX: begin imp_x = sp_reg;  imp_status = with_nz(status_reg, sp_reg);  end
            mcs_pkg::K_TXA: begin imp_acc = x_reg; imp_status = with_nz(status_reg, x_reg);   end
            mcs_pkg::K_TYA: begin imp_acc = y_reg; imp_status = with_nz(status_reg, y_reg);   end
            mcs_pkg::K_TXS: imp_sp = x_reg;
            mcs_pkg::K_CLC: imp_status[mcs_pkg::FLAG_C] = 1'b0;
            mcs_pkg::K_SEC: imp_status[mcs_pkg::FLAG_C] = 1'b1;
            mcs_pkg::K_BRK: begin imp_halt = 1'b1; imp_brk = 1'b1; end
            default: begin imp_halt = 1'b1; imp_illegal = 1'b1; end
        endcase
    end

    // Absolute and indirect address sums wrap within 16 bits.
    assign abs_base  = {rd, ea_reg[7:0]};
    assign abs_index = (dec_op.mode == mcs_pkg::M_ABX) ? {8'h00, x_reg} :
                       (dec_op.mode == mcs_pkg::M_ABY) ? {8'h00, y_reg} : 16'h0000;
    assign ind_base  = {rd, ea_reg[7:0]};
    assign ind_index = (dec_op.mode == mcs_pkg::M_INDY) ? {8'h00, y_reg} : 16'h0000;

    // Next state of the core for the request being accepted.
    always_comb begin
        acc_next     = acc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        sp_next      = sp_reg;
        status_next  = status_reg;
        pc_next      = pc_reg;
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        ea_next      = ea_reg;
        ptr_next     = ptr_reg;
        halt_next    = halt_reg;
        illegal_next = illegal_reg;
        unique case (op_in)
            mcs_pkg::OP_RESTART: begin
                acc_next     = 8'h00;
                x_next       = 8'h00;
                y_next       = 8'h00;
                sp_next      = mcs_pkg::RESET_SP;
                status_next  = mcs_pkg::RESET_STATUS;
                pc_next      = start_addr_reg;
                phase_next   = mcs_pkg::PH_OPC;
                opcode_next  = 8'h00;
                ea_next      = 16'h0000;
                ptr_next     = 16'h0000;
                halt_next    = 1'b0;
                illegal_next = 1'b0;
            end
            mcs_pkg::OP_RESUME: begin
                if (halt_reg) begin
                    halt_next    = 1'b0;
                    illegal_next = 1'b0;
                    phase_next   = mcs_pkg::PH_OPC;
                end
            end
            mcs_pkg::OP_RESPONSE: begin
                if (!halt_reg) begin
                    unique case (phase_reg)
                        mcs_pkg::PH_OPC: begin
                            opcode_next = rd;
                            pc_next     = pc_reg + 16'd1;
                            if (dec_rd.mode == mcs_pkg::M_IMP) begin
                                acc_next     = imp_acc;
                                x_next       = imp_x;
                                y_next       = imp_y;
                                sp_next      = imp_sp;
                                status_next  = imp_status;
                                halt_next    = imp_halt;
                                illegal_next = imp_illegal;
                                // BRK also skips its padding byte.
                                if (imp_brk) begin
                                    pc_next = pc_reg + 16'd2;
                                end
                            end else begin
                                phase_next = mcs_pkg::PH_LO;
                            end
                        end
                        mcs_pkg::PH_LO: begin
                            pc_next = pc_reg + 16'd1;
                            unique case (dec_op.mode)
                                mcs_pkg::M_IMM: begin
                                    acc_next    = val_acc;
                                    x_next      = val_x;
                                    y_next      = val_y;
                                    status_next = val_status;
                                    phase_next  = mcs_pkg::PH_OPC;
                                end
                                mcs_pkg::M_ZPG: begin
                                    ea_next    = {8'h00, rd};
                                    phase_next = store_phase;
                                end
                                mcs_pkg::M_ZPX: begin
                                    ea_next    = {8'h00, rd + x_reg};
                                    phase_next = store_phase;
                                end
                                mcs_pkg::M_ZPY: begin
                                    ea_next    = {8'h00, rd + y_reg};
                                    phase_next = store_phase;
                                end
                                mcs_pkg::M_XIND: begin
                                    ptr_next   = {8'h00, rd + x_reg};
                                    phase_next = mcs_pkg::PH_PLO;
                                end
                                mcs_pkg::M_INDY: begin
                                    ptr_next   = {8'h00, rd};
                                    phase_next = mcs_pkg::PH_PLO;
                                end
                                mcs_pkg::M_IND: begin
                                    ptr_next   = {8'h00, rd};
                                    phase_next = mcs_pkg::PH_HI;
                                end
                                default: begin
                                    ea_next    = {8'h00, rd};
                                    phase_next = mcs_pkg::PH_HI;
                                end
                            endcase
                        end
                        mcs_pkg::PH_HI: begin
                            pc_next = pc_reg + 16'd1;
                            if (dec_op.mode == mcs_pkg::M_IND) begin
                                ptr_next   = {rd, ptr_reg[7:0]};
                                phase_next = mcs_pkg::PH_PLO;
                            end else begin
                                ea_next = abs_base + abs_index;
                                if (dec_op.kind == mcs_pkg::K_JMP) begin
                                    pc_next    = abs_base;
                                    phase_next = mcs_pkg::PH_OPC;
                                end else begin
                                    phase_next = store_phase;
                                end
                            end
                        end
                        mcs_pkg::PH_PLO: begin
                            ea_next    = {8'h00, rd};
                            phase_next = mcs_pkg::PH_PHI;
                        end
                        mcs_pkg::PH_PHI: begin
                            if (dec_op.mode == mcs_pkg::M_IND) begin
                                ea_next    = ind_base;
                                pc_next    = ind_base;
                                phase_next = mcs_pkg::PH_OPC;
                            end else begin
                                ea_next    = ind_base + ind_index;
                                phase_next = store_phase;
                            end
                        end
                        mcs_pkg::PH_DATA: begin
                            acc_next    = val_acc;
                            x_next      = val_x;
                            y_next      = val_y;
                            status_next = val_status;
                            phase_next  = mcs_pkg::PH_OPC;
                        end
                        default: begin
                            // After a write the response byte means nothing.
                            phase_next = mcs_pkg::PH_OPC;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Request named by the state after this step.
    always_comb begin
        req_valid = !halt_next;
        req_addr  = 16'h0000;
        req_write = 1'b0;
        req_wdata = 8'h00;
        if (!halt_next) begin
            unique case (phase_next)
                mcs_pkg::PH_PLO: req_addr = ptr_next;
                mcs_pkg::PH_PHI: begin
                    // Zero-page pointers wrap in page zero; JMP indirect carries.
                    if (dec_nx.mode == mcs_pkg::M_IND) begin
                        req_addr = ptr_next + 16'd1;
                    end else begin
                        req_addr = {8'h00, ptr_next[7:0] + 8'd1};
                    end
                end
                mcs_pkg::PH_DATA: req_addr = ea_next;
                mcs_pkg::PH_WRITE: begin
                    req_addr  = ea_next;
                    req_write = 1'b1;
                    req_wdata = (dec_nx.kind == mcs_pkg::K_STX) ? x_next :
                                (dec_nx.kind == mcs_pkg::K_STY) ? y_next : acc_next;
                end
                default: req_addr = pc_next;
            endcase
        end
    end

    assign m_tdata_next = {5'b00000, illegal_next, halt_next, pc_next, status_next, sp_next,
                           y_next, x_next, acc_next, req_wdata, req_addr, req_valid};
    assign m_tuser_next = req_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg <= mcs_pkg::RESET_PC;
        end else if (cfg_wr_en) begin
            start_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= 8'h00;
            x_reg        <= 8'h00;
            y_reg        <= 8'h00;
            sp_reg       <= mcs_pkg::RESET_SP;
            status_reg   <= mcs_pkg::RESET_STATUS;
            pc_reg       <= mcs_pkg::RESET_PC;
            phase_reg    <= mcs_pkg::PH_OPC;
            opcode_reg   <= 8'h00;
            ea_reg       <= 16'h0000;
            ptr_reg      <= 16'h0000;
            halt_reg     <= 1'b0;
            illegal_reg  <= 1'b0;
        end else if (s_fire) begin
            acc_reg      <= acc_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            sp_reg       <= sp_next;
            status_reg   <= status_next;
            pc_reg       <= pc_next;
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            ea_reg       <= ea_next;
            ptr_reg      <= ptr_next;
            halt_reg     <= halt_next;
            illegal_reg  <= illegal_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

FILE: hw/rtl/mcs_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_chk
// Port-level checks of the 6502 subset core, bound to its top level.
// ----------------------------------------------------------------------------
`include "mos6502_core_subset_assert.svh"

module mcs_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic        stalled;
    logic [88:0] res_word;
    logic        res_req;
    logic        res_write;
    logic        res_halted;
    logic        res_illegal;
    logic        res_quiet;
    logic        res_sane;
    logic        halt_shown;

    assign stalled     = m_tvalid && !m_tready;
    assign res_word    = {m_tuser, m_tdata};
    assign res_req     = m_tdata[mcs_pkg::OUT_REQ_BIT];
    assign res_write   = m_tuser[0];
    assign res_halted  = m_tdata[mcs_pkg::OUT_HALT_BIT];
    assign res_illegal = m_tdata[mcs_pkg::OUT_ILL_BIT];
    assign res_quiet   = !res_req && !res_write &&
                         (m_tdata[mcs_pkg::OUT_ADDR_LSB +: 16] == 16'h0000) &&
                         (m_tdata[mcs_pkg::OUT_WDATA_LSB +: 8] == 8'h00);
    assign res_sane    = (!res_write || res_req) && m_tdata[mcs_pkg::OUT_FLAGS_LSB + 5];
    assign halt_shown  = m_tvalid && (res_halted || res_illegal);

    // A stalled result keeps its word.
    `MCS_ASSERT_NEXT(a_stall_hold, stalled, m_tvalid && $stable(res_word), "stalled result changed")

    // Every accepted request leaves a result in the output register.
    `MCS_ASSERT_NEXT(a_accept_result, s_tvalid && s_tready, m_tvalid, "request gave no result")

    // A halted core requests nothing, and an illegal halt is a halt.
    `MCS_ASSERT_SAME(a_halt_quiet, halt_shown, res_halted && res_quiet, "halted result not quiet")

    // Only a running core writes, and the flags byte always has bit five set.
    `MCS_ASSERT_SAME(a_write_running, m_tvalid, res_sane, "bad write request or flags")

endmodule

bind mos6502_core_subset mcs_chk u_mcs_chk (.*);

FILE: bench/mos6502_core_subset_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos6502_core_subset_tb
// Self-checking bench for the 6502 subset core. The bench plays the memory
// side of the bus: it answers every access the core asks for, and a shadow
// copy of the core predicts the next access, the register file and the halt
// status for every accepted request. A short directed part covers the address
// wrap rules, the arithmetic flags, halting, resuming and the start address.
// Random programs with random operand bytes then run under bursty requests and
// a stalling receiver.
// ----------------------------------------------------------------------------
module mos6502_core_subset_tb;

    // Everything one result word tells about the core.
    typedef struct {
        logic        req;
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic        halted;
        logic        illegal;
    } core_view_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] read_data
    logic [1:0]  s_tuser;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // request, address, store data, registers, pc, halt, illegal
    logic [0:0]  m_tuser;   // [0] is_write

    mos6502_core_subset u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the core.
    // ------------------------------------------------------------------------
    logic [15:0]      core_start;
    logic [7:0]       core_acc, core_x, core_y, core_sp, core_status, core_opcode;
    logic [15:0]      core_pc, core_ea, core_ptr;
    mcs_pkg::phase_t  core_phase;
    logic             core_halted, core_illegal;

    core_view_t  predicted_results[$];
    int          mismatch_count = 0;
    int          burst_left = 0;

    // Opcode to addressing mode and instruction class.
    function automatic void classify_opcode(input logic [7:0] op, output mcs_pkg::mode_t mode,
                                            output mcs_pkg::kind_t kind);
        mode = mcs_pkg::M_IMP;
        kind = mcs_pkg::K_ILL;
        case (op)
            8'h00: kind = mcs_pkg::K_BRK;
            8'h18: kind = mcs_pkg::K_CLC;
            8'h38: kind = mcs_pkg::K_SEC;
            8'hAA: kind = mcs_pkg::K_TAX;
            8'hA8: kind = mcs_pkg::K_TAY;
            8'hBA: kind = mcs_pkg::K_TSX;
            8'h8A: kind = mcs_pkg::K_TXA;
            8'h9A: kind = mcs_pkg::K_TXS;
            8'h98: kind = mcs_pkg::K_TYA;
            8'h4C: begin kind = mcs_pkg::K_JMP; mode = mcs_pkg::M_ABS; end
            8'h6C: begin kind = mcs_pkg::K_JMP; mode = mcs_pkg::M_IND; end
            8'hA2: begin kind = mcs_pkg::K_LDX; mode = mcs_pkg::M_IMM; end
            8'hA6: begin kind = mcs_pkg::K_LDX; mode = mcs_pkg::M_ZPG; end
            8'hAE: begin kind = mcs_pkg::K_LDX; mode = mcs_pkg::M_ABS; end
            8'hB6: begin kind = mcs_pkg::K_LDX; mode = mcs_pkg::M_ZPY; end
            8'hBE: begin kind = mcs_pkg::K_LDX; mode = mcs_pkg::M_ABY; end
            8'hA0: begin kind = mcs_pkg::K_LDY; mode = mcs_pkg::M_IMM; end
            8'hA4: begin kind = mcs_pkg::K_LDY; mode = mcs_pkg::M_ZPG; end
            8'hAC: begin kind = mcs_pkg::K_LDY; mode = mcs_pkg::M_ABS; end
            8'hB4: begin kind = mcs_pkg::K_LDY; mode = mcs_pkg::M_ZPX; end
            8'hBC: begin kind = mcs_pkg::K_LDY; mode = mcs_pkg::M_ABX; end
            8'h86: begin kind = mcs_pkg::K_STX; mode = mcs_pkg::M_ZPG; end
            8'h8E: begin kind = mcs_pkg::K_STX; mode = mcs_pkg::M_ABS; end
            8'h96: begin kind = mcs_pkg::K_STX; mode = mcs_pkg::M_ZPY; end
            8'h84: begin kind = mcs_pkg::K_STY; mode = mcs_pkg::M_ZPG; end
            8'h8C: begin kind = mcs_pkg::K_STY; mode = mcs_pkg::M_ABS; end
            8'h94: begin kind = mcs_pkg::K_STY; mode = mcs_pkg::M_ZPX; end
            8'hEB: begin kind = mcs_pkg::K_SBC; mode = mcs_pkg::M_IMM; end
            default: begin
                // The arithmetic and accumulator load/store group sits in the
                // column-one opcodes; STA has no immediate form.
                if (op[1:0] == 2'b01) begin
                    case (op[7:5])
                        3'd3: kind = mcs_pkg::K_ADC;
                        3'd7: kind = mcs_pkg::K_SBC;
                        3'd5: kind = mcs_pkg::K_LDA;
                        3'd4: if (op[4:2] != 3'd2) kind = mcs_pkg::K_STA;
                        default: ;
                    endcase
                    if (kind != mcs_pkg::K_ILL) begin
                        case (op[4:2])
                            3'd0: mode = mcs_pkg::M_XIND;
                            3'd1: mode = mcs_pkg::M_ZPG;
                            3'd2: mode = mcs_pkg::M_IMM;
                            3'd3: mode = mcs_pkg::M_ABS;
                            3'd4: mode = mcs_pkg::M_INDY;
                            3'd5: mode = mcs_pkg::M_ZPX;
                            3'd6: mode = mcs_pkg::M_ABY;
                            default: mode = mcs_pkg::M_ABX;
                        endcase
                    end
                end
            end
        endcase
    endfunction

    function automatic void set_nz(logic [7:0] v);
        core_status[mcs_pkg::FLAG_Z] = (v == 8'h00);
        core_status[mcs_pkg::FLAG_N] = v[7];
    endfunction

    function automatic void add_to_acc(logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, core_acc} + {1'b0, m} + {8'h00, core_status[mcs_pkg::FLAG_C]};
        r = sum[7:0];
        core_status[mcs_pkg::FLAG_C] = sum[8];
        core_status[mcs_pkg::FLAG_V] = ~(core_acc[7] ^ m[7]) & (core_acc[7] ^ r[7]);
        core_acc = r;
        set_nz(r);
    endfunction

    function automatic void use_operand(mcs_pkg::kind_t kind, logic [7:0] d);
        case (kind)
            mcs_pkg::K_ADC: add_to_acc(d);
            mcs_pkg::K_SBC: add_to_acc(~d);
            mcs_pkg::K_LDA: begin core_acc = d; set_nz(d); end
            mcs_pkg::K_LDX: begin core_x = d; set_nz(d); end
            mcs_pkg::K_LDY: begin core_y = d; set_nz(d); end
            default: ;
        endcase
    endfunction

    function automatic void enter_access(mcs_pkg::kind_t kind);
        if (kind == mcs_pkg::K_STA || kind == mcs_pkg::K_STX || kind == mcs_pkg::K_STY)
            core_phase = mcs_pkg::PH_WRITE;
        else
            core_phase = mcs_pkg::PH_DATA;
    endfunction

    function automatic void run_implied(mcs_pkg::kind_t kind);
        case (kind)
            mcs_pkg::K_TAX: begin core_x = core_acc; set_nz(core_x); end
            mcs_pkg::K_TAY: begin core_y = core_acc; set_nz(core_y); end
            mcs_pkg::K_TSX: begin core_x = core_sp; set_nz(core_x); end
            mcs_pkg::K_TXA: begin core_acc = core_x; set_nz(core_acc); end
            mcs_pkg::K_TYA: begin core_acc = core_y; set_nz(core_acc); end
            mcs_pkg::K_TXS: core_sp = core_x;
            mcs_pkg::K_CLC: core_status[mcs_pkg::FLAG_C] = 1'b0;
            mcs_pkg::K_SEC: core_status[mcs_pkg::FLAG_C] = 1'b1;
            mcs_pkg::K_BRK: begin
                // The padding byte after BRK is skipped, not read.
                core_pc = core_pc + 16'd1;
                core_halted = 1'b1;
            end
            default: begin
                core_halted = 1'b1;
                core_illegal = 1'b1;
            end
        endcase
        core_phase = mcs_pkg::PH_OPC;
    endfunction

    // One bus response while running: advance one microstep.
    function automatic void advance_core(logic [7:0] d);
        mcs_pkg::mode_t mode;
        mcs_pkg::kind_t kind;
        if (core_phase == mcs_pkg::PH_OPC) begin
            core_opcode = d;
            core_pc = core_pc + 16'd1;
            classify_opcode(d, mode, kind);
            if (mode == mcs_pkg::M_IMP)
                run_implied(kind);
            else
                core_phase = mcs_pkg::PH_LO;
        end else begin
            classify_opcode(core_opcode, mode, kind);
            case (core_phase)
                mcs_pkg::PH_LO: begin
                    core_pc = core_pc + 16'd1;
                    case (mode)
                        mcs_pkg::M_IMM: begin
                            use_operand(kind, d);
                            core_phase = mcs_pkg::PH_OPC;
                        end
                        mcs_pkg::M_ZPG: begin
                            core_ea = {8'h00, d};
                            enter_access(kind);
                        end
                        // Zero-page indexing stays inside page zero.
                        mcs_pkg::M_ZPX: begin
                            core_ea = {8'h00, d + core_x};
                            enter_access(kind);
                        end
                        mcs_pkg::M_ZPY: begin
                            core_ea = {8'h00, d + core_y};
                            enter_access(kind);
                        end
                        mcs_pkg::M_XIND: begin
                            core_ptr = {8'h00, d + core_x};
                            core_phase = mcs_pkg::PH_PLO;
                        end
                        mcs_pkg::M_INDY: begin
                            core_ptr = {8'h00, d};
                            core_phase = mcs_pkg::PH_PLO;
                        end
                        mcs_pkg::M_IND: begin
                            core_ptr = {8'h00, d};
                            core_phase = mcs_pkg::PH_HI;
                        end
                        default: begin
                            core_ea = {8'h00, d};
                            core_phase = mcs_pkg::PH_HI;
                        end
                    endcase
                end
                mcs_pkg::PH_HI: begin
                    core_pc = core_pc + 16'd1;
                    if (mode == mcs_pkg::M_IND) begin
                        core_ptr = {d, core_ptr[7:0]};
                        core_phase = mcs_pkg::PH_PLO;
                    end else begin
                        core_ea = {d, core_ea[7:0]};
                        if (mode == mcs_pkg::M_ABX) core_ea = core_ea + {8'h00, core_x};
                        if (mode == mcs_pkg::M_ABY) core_ea = core_ea + {8'h00, core_y};
                        if (kind == mcs_pkg::K_JMP) begin
                            core_pc = core_ea;
                            core_phase = mcs_pkg::PH_OPC;
                        end else begin
                            enter_access(kind);
                        end
                    end
                end
                mcs_pkg::PH_PLO: begin
                    core_ea = {8'h00, d};
                    core_phase = mcs_pkg::PH_PHI;
                end
                mcs_pkg::PH_PHI: begin
                    core_ea = {d, core_ea[7:0]};
                    if (mode == mcs_pkg::M_IND) begin
                        core_pc = core_ea;
                        core_phase = mcs_pkg::PH_OPC;
                    end else begin
                        if (mode == mcs_pkg::M_INDY) core_ea = core_ea + {8'h00, core_y};
                        enter_access(kind);
                    end
                end
                mcs_pkg::PH_DATA: begin
                    use_operand(kind, d);
                    core_phase = mcs_pkg::PH_OPC;
                end
                default: core_phase = mcs_pkg::PH_OPC;  // the byte after a write is ignored
            endcase
        end
    endfunction

    function automatic void restart_core();
        core_acc = 8'h00;
        core_x = 8'h00;
        core_y = 8'h00;
        core_sp = mcs_pkg::RESET_SP;
        core_status = mcs_pkg::RESET_STATUS;
        core_pc = core_start;
        core_phase = mcs_pkg::PH_OPC;
        core_opcode = 8'h00;
        core_ea = 16'h0000;
        core_ptr = 16'h0000;
        core_halted = 1'b0;
        core_illegal = 1'b0;
    endfunction

    // Applies one accepted request and returns the result the core must show.
    function automatic core_view_t step_core(mcs_pkg::operation_t op, logic [7:0] d);
        core_view_t     v;
        mcs_pkg::mode_t mode;
        mcs_pkg::kind_t kind;
        case (op)
            mcs_pkg::OP_RESTART: restart_core();
            mcs_pkg::OP_RESUME: begin
                if (core_halted) begin
                    core_halted = 1'b0;
                    core_illegal = 1'b0;
                    core_phase = mcs_pkg::PH_OPC;
                end
            end
            mcs_pkg::OP_RESPONSE: if (!core_halted) advance_core(d);
            default: ;
        endcase

        v = '{default: '0};
        if (!core_halted) begin
            v.req = 1'b1;
            classify_opcode(core_opcode, mode, kind);
            case (core_phase)
                mcs_pkg::PH_PLO: v.addr = core_ptr;
                // The indirect jump carries into the next page; the zero-page
                // pointers wrap inside page zero.
                mcs_pkg::PH_PHI: begin
                    v.addr = (mode == mcs_pkg::M_IND) ? core_ptr + 16'd1
                                                      : {8'h00, core_ptr[7:0] + 8'h01};
                end
                mcs_pkg::PH_DATA: v.addr = core_ea;
                mcs_pkg::PH_WRITE: begin
                    v.addr = core_ea;
                    v.wr = 1'b1;
                    v.wdata = (kind == mcs_pkg::K_STX) ? core_x :
                              (kind == mcs_pkg::K_STY) ? core_y : core_acc;
                end
                default: v.addr = core_pc;
            endcase
        end
        v.acc = core_acc;
        v.x = core_x;
        v.y = core_y;
        v.sp = core_sp;
        v.flags = core_status;
        v.pc = core_pc;
        v.halted = core_halted;
        v.illegal = core_illegal;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Tasks start and end on a falling edge.
    // ------------------------------------------------------------------------

    // Sends one request in bursts of random length with random gaps, waits for
    // the handshake and records the predicted result.
    task automatic send_request(mcs_pkg::operation_t op, logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        predicted_results.push_back(step_core(op, d));
        @(negedge aclk);
    endtask

    // Lowers the request and waits until every predicted result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_start_address(logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        core_start = value;
    endtask

    // ------------------------------------------------------------------------
    // Result side: receiver stalls and the checker.
    // ------------------------------------------------------------------------

    // The receiver switches between always ready, coin-flip, rare stalls and
    // long stalls, so that stalls land on every microstep.
    initial begin
        int pattern;
        int left;
        int stall;
        pattern = 0;
        left = 0;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                pattern = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: begin
                    if (stall > 0) begin
                        stall--;
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        core_view_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, actual %h / %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = predicted_results.pop_front();
                check_field("request_valid", want.req, m_tdata[0]);
                check_field("bus_address", want.addr, m_tdata[16:1]);
                check_field("is_write", want.wr, m_tuser[0]);
                check_field("write_data", want.wdata, m_tdata[24:17]);
                check_field("accumulator", want.acc, m_tdata[32:25]);
                check_field("index_x", want.x, m_tdata[40:33]);
                check_field("index_y", want.y, m_tdata[48:41]);
                check_field("stack_pointer", want.sp, m_tdata[56:49]);
                check_field("flags", want.flags, m_tdata[64:57]);
                check_field("program_counter", want.pc, m_tdata[80:65]);
                check_field("halted", want.halted, m_tdata[81]);
                check_field("illegal", want.illegal, m_tdata[82]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A short program that hits the arithmetic flags and the address wraps.
    task automatic test_addressing_and_flags();
        send_request(mcs_pkg::OP_RESPONSE, 8'hA9);   // LDA #$80: negative result
        send_request(mcs_pkg::OP_RESPONSE, 8'h80);
        send_request(mcs_pkg::OP_RESPONSE, 8'h69);   // ADC #$80: carry, overflow and zero
        send_request(mcs_pkg::OP_RESPONSE, 8'h80);
        send_request(mcs_pkg::OP_RESPONSE, 8'hEB);   // the alias of SBC immediate
        send_request(mcs_pkg::OP_RESPONSE, 8'h01);
        send_request(mcs_pkg::OP_RESPONSE, 8'hA2);   // LDX #$FF
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        // LDA ($00,X): pointer at $FF, high byte at $00.
        send_request(mcs_pkg::OP_RESPONSE, 8'hA1);
        send_request(mcs_pkg::OP_RESPONSE, 8'h00);
        send_request(mcs_pkg::OP_RESPONSE, 8'h34);
        send_request(mcs_pkg::OP_RESPONSE, 8'h12);
        send_request(mcs_pkg::OP_RESPONSE, 8'h55);
        send_request(mcs_pkg::OP_RESPONSE, 8'hA8);   // TAY
        // STA ($FF),Y: base $FFFF plus Y wraps to page zero.
        send_request(mcs_pkg::OP_RESPONSE, 8'h91);
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'hA5);   // the byte after the write is ignored
        send_request(mcs_pkg::OP_RESPONSE, 8'h6C);   // JMP ($12FF): high byte read from $1300
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'h12);
        send_request(mcs_pkg::OP_RESPONSE, 8'h00);
        send_request(mcs_pkg::OP_RESPONSE, 8'h80);
    endtask

    task automatic test_halt_and_resume();
        send_request(mcs_pkg::OP_RESPONSE, 8'h00);   // BRK skips its padding byte and halts
        send_request(mcs_pkg::OP_RESPONSE, 8'h5A);   // ignored while halted
        send_request(mcs_pkg::OP_NONE, 8'hC3);
        send_request(mcs_pkg::OP_RESUME, 8'h00);
        send_request(mcs_pkg::OP_RESUME, 8'hFF);     // resume while running repeats the request
        send_request(mcs_pkg::OP_RESPONSE, 8'hEA);   // NOP is not supported: illegal halt
        send_request(mcs_pkg::OP_RESUME, 8'h00);
    endtask

    // Restarts from both extremes of the start address; the fetch at $FFFF
    // wraps the program counter to zero.
    task automatic test_start_address();
        drain_results();
        write_start_address(16'hFFFF);
        send_request(mcs_pkg::OP_RESTART, 8'h00);
        send_request(mcs_pkg::OP_RESPONSE, 8'hA9);
        send_request(mcs_pkg::OP_RESPONSE, 8'h7F);
        drain_results();
        write_start_address(16'h0000);
        send_request(mcs_pkg::OP_RESTART, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'h4C);
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
        send_request(mcs_pkg::OP_RESPONSE, 8'hFF);
    endtask

    // Mostly supported opcodes, so that programs run deep; a few raw bytes
    // bring in illegal halts.
    function automatic logic [7:0] pick_opcode();
        logic [7:0]     op;
        mcs_pkg::mode_t mode;
        mcs_pkg::kind_t kind;
        if ($urandom_range(0, 99) < 5) return 8'($urandom_range(0, 255));
        do begin
            op = 8'($urandom_range(0, 255));
            classify_opcode(op, mode, kind);
        end while (kind == mcs_pkg::K_ILL);
        return op;
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'h00;
                1: return 8'hFF;
                2: return 8'h7F;
                default: return 8'h80;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random programs: the bench answers each access the core asks for, with
    // a sprinkle of restarts, stray resumes and unused operation codes.
    task automatic run_random_program(int count);
        int                  done;
        int                  r;
        logic                ignored;
        mcs_pkg::operation_t op;
        logic [7:0]          d;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            d = pick_operand();
            if (core_halted) begin
                op = (r < 80) ? mcs_pkg::OP_RESUME : (r < 90) ? mcs_pkg::OP_RESTART :
                     (r < 95) ? mcs_pkg::OP_RESPONSE : mcs_pkg::OP_NONE;
            end else if (r < 2) begin
                op = mcs_pkg::OP_RESTART;
            end else if (r < 3) begin
                op = mcs_pkg::OP_RESUME;
            end else if (r < 4) begin
                op = mcs_pkg::OP_NONE;
            end else begin
                op = mcs_pkg::OP_RESPONSE;
                if (core_phase == mcs_pkg::PH_OPC) d = pick_opcode();
            end
            ignored = (op == mcs_pkg::OP_NONE) ||
                      (op == mcs_pkg::OP_RESUME && !core_halted) ||
                      (op == mcs_pkg::OP_RESPONSE && core_halted);
            send_request(op, d);
            if (!ignored) done++;
        end
    endtask

    task automatic test_random_programs();
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            drain_results();
            write_start_address(phase_no == 0 ? mcs_pkg::RESET_PC
                                              : 16'($urandom_range(0, 65535)));
            send_request(mcs_pkg::OP_RESTART, pick_operand());
            run_random_program(270);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'h0000;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = mcs_pkg::OP_RESPONSE;
        core_start = mcs_pkg::RESET_PC;
        restart_core();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // After reset the opcode read at $C000 counts as already requested.
        test_addressing_and_flags();
        test_halt_and_resume();
        test_start_address();
        test_random_programs();

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mcs_pkg.sv
hw/rtl/mos6502_core_subset.sv
hw/rtl/mcs_chk.sv
bench/mos6502_core_subset_tb.sv
